/* hdl/rc_serial_frame_receiver_defines.svh */
// Assertion macros for the RC serial frame receiver.
// Used by the top level only; needs nothing else.
`ifndef RC_SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define RC_SERIAL_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCSFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsfr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RCSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsfr: next-cycle check failed");

`endif

/* hdl/rcsfr_pkg.sv */
// Shared constants and controller/datapath command and status types
// for the RC serial frame receiver. No dependencies.
package rcsfr_pkg;

    localparam int FRAME_BYTES  = 32;
    localparam int CHANNELS_DEF = 14;
    localparam int POS_W        = 5;

    localparam logic [7:0]       BYTE_LEN      = 8'h20;
    localparam logic [7:0]       BYTE_CMD      = 8'h40;
    localparam logic [15:0]      SUM_BASE      = 16'hFFFF;
    localparam logic [15:0]      TIMEOUT_RESET = 16'd100;
    localparam logic [15:0]      AGE_MAX       = 16'hFFFF;
    localparam logic [POS_W-1:0] POS_SUM_END   = POS_W'(FRAME_BYTES - 3);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_CHANNEL = 1'b1;

    typedef struct packed {
        logic tick;
        logic start_len;
        logic start_cmd;
        logic pay;
        logic frame_good;
        logic frame_bad;
        logic load_status;
        logic load_word;
        logic ch_clear;
        logic ch_inc;
    } rcsfr_cmd_t;

    typedef struct packed {
        logic is_len;
        logic is_cmd;
        logic pos_last;
        logic frame_good;
        logic ch_last;
        logic out_free;
    } rcsfr_sts_t;

endpackage

/* hdl/rcsfr_in_if.sv */
// Request channel interface: one received byte or one millisecond tick.
// Standalone; valid/ready handshake.
interface rcsfr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

/* hdl/rcsfr_out_if.sv */
// Result channel interface: channel words and status of the receiver.
// Standalone; valid/ready handshake.
interface rcsfr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        last;
    logic        checksum_error;
    logic        link_timeout;
    logic        link_seen;
    logic [15:0] good_frames;
    logic [15:0] bad_frames;

    modport source (output valid, output kind, output channel_index, output channel_value,
                    output last, output checksum_error, output link_timeout,
                    output link_seen, output good_frames, output bad_frames,
                    input ready);
    modport sink   (input valid, input kind, input channel_index, input channel_value,
                    input last, input checksum_error, input link_timeout,
                    input link_seen, input good_frames, input bad_frames,
                    output ready);
endinterface

/* hdl/rcsfr_ctrl.sv */
// Controller: frame hunter and channel emit sequencer.
// Depends on rcsfr_pkg; drives the datapath through rcsfr_cmd_t.
module rcsfr_ctrl
    import rcsfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_action,
    output logic       in_ready,
    input  rcsfr_sts_t sts,
    output rcsfr_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    localparam logic [1:0] HS_LEN = 2'd0;
    localparam logic [1:0] HS_CMD = 2'd1;
    localparam logic [1:0] HS_PAY = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] hunt_reg, hunt_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        hunt_next  = hunt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_action)
                    begin
                        cmd.tick        = 1'b1;
                        cmd.load_status = 1'b1;
                    end
                    else
                    begin
                        cmd.load_status = 1'b1;
                        case (hunt_reg)
                            HS_CMD:
                            begin
                                if (sts.is_cmd)
                                begin
                                    cmd.start_cmd = 1'b1;
                                    hunt_next     = HS_PAY;
                                end
                                else if (!sts.is_len)
                                begin
                                    hunt_next = HS_LEN;
                                end
                            end
                            HS_PAY:
                            begin
                                cmd.pay = 1'b1;
                                if (sts.pos_last)
                                begin
                                    hunt_next = HS_LEN;
                                    if (sts.frame_good)
                                    begin
                                        cmd.frame_good  = 1'b1;
                                        cmd.load_status = 1'b0;
                                        cmd.ch_clear    = 1'b1;
                                        state_next      = ST_FETCH;
                                    end
                                    else
                                    begin
                                        cmd.frame_bad = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                // unused hunter code acts as waiting for length
                                if (sts.is_len)
                                begin
                                    cmd.start_len = 1'b1;
                                    hunt_next     = HS_CMD;
                                end
                                else
                                begin
                                    hunt_next = HS_LEN;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_word = 1'b1;
                    if (sts.ch_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.ch_inc = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hunt_reg  <= HS_LEN;
        end
        else
        begin
            state_reg <= state_next;
            hunt_reg  <= hunt_next;
        end
    end

endmodule

/* hdl/rcsfr_dpath.sv */
// Datapath: byte position, running checksum, channel word store, link age,
// counters and the result register. Depends on rcsfr_pkg and rcsfr_out_if.
module rcsfr_dpath
    import rcsfr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic [7:0]  in_byte,
    input  rcsfr_cmd_t  cmd,
    output rcsfr_sts_t  sts,
    rcsfr_out_if.source result
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [15:0]      timeout_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       chk_lo_reg;
    logic [7:0]       lo_hold_reg;
    logic [15:0]      age_reg, age_next;
    logic             seen_reg, seen_next;
    logic             lost_reg, lost_next;
    logic [15:0]      good_reg, good_next;
    logic [15:0]      bad_reg, bad_next;
    logic [3:0]       ch_reg;
    logic [15:0]      rd_data_reg;
    logic [15:0]      word_mem [CHANNELS];
    logic [3:0]       widx;
    logic             wr_word;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [3:0]       out_index_reg;
    logic [15:0]      out_value_reg;
    logic             out_last_reg;
    logic             out_err_reg;
    logic             out_lost_reg;
    logic             out_seen_reg;
    logic [15:0]      out_good_reg;
    logic [15:0]      out_bad_reg;

    assign sts.is_len     = (in_byte == BYTE_LEN);
    assign sts.is_cmd     = (in_byte == BYTE_CMD);
    assign sts.pos_last   = (pos_reg == POS_LAST);
    assign sts.frame_good = ((SUM_BASE - sum_reg) == {in_byte, chk_lo_reg});
    assign sts.ch_last    = (ch_reg == 4'(CHANNELS - 1));
    assign sts.out_free   = !out_valid_reg || result.ready;

    // channel k sits in bytes 2k+2 (low) and 2k+3 (high)
    assign widx    = pos_reg[4:1] - 4'd1;
    assign wr_word = cmd.pay && pos_reg[0] && (pos_reg >= POS_W'(3))
                     && (pos_reg <= POS_SUM_END) && (widx < 4'(CHANNELS));

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        age_next  = age_reg;
        seen_next = seen_reg;
        lost_next = lost_reg;
        good_next = good_reg;
        bad_next  = bad_reg;
        if (cmd.start_len)
        begin
            pos_next = POS_W'(1);
            sum_next = {8'd0, BYTE_LEN};
        end
        if (cmd.start_cmd)
        begin
            pos_next = POS_W'(2);
            sum_next = sum_reg + {8'd0, BYTE_CMD};
        end
        if (cmd.pay)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg <= POS_SUM_END)
            begin
                sum_next = sum_reg + {8'd0, in_byte};
            end
        end
        if (cmd.tick)
        begin
            if (age_reg != AGE_MAX)
            begin
                age_next = age_reg + 16'd1;
            end
            if (seen_reg)
            begin
                lost_next = (age_next > timeout_reg);
            end
        end
        if (cmd.frame_good)
        begin
            age_next  = '0;
            seen_next = 1'b1;
            lost_next = 1'b0;
            good_next = good_reg + 16'd1;
        end
        if (cmd.frame_bad)
        begin
            bad_next = bad_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            pos_reg       <= '0;
            age_reg       <= '0;
            seen_reg      <= 1'b0;
            lost_reg      <= 1'b0;
            good_reg      <= '0;
            bad_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            pos_reg  <= pos_next;
            age_reg  <= age_next;
            seen_reg <= seen_next;
            lost_reg <= lost_next;
            good_reg <= good_next;
            bad_reg  <= bad_next;
            if (cmd.ch_clear)
            begin
                ch_reg <= '0;
            end
            else if (cmd.ch_inc)
            begin
                ch_reg <= ch_reg + 4'd1;
            end
            if (cmd.load_status || cmd.load_word)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (cmd.pay && (pos_reg == POS_SUM_END + POS_W'(1)))
        begin
            chk_lo_reg <= in_byte;
        end
        if (cmd.pay && !pos_reg[0])
        begin
            lo_hold_reg <= in_byte;
        end
        if (cmd.load_status || cmd.load_word)
        begin
            out_kind_reg  <= cmd.load_word ? KIND_CHANNEL : KIND_STATUS;
            out_index_reg <= cmd.load_word ? ch_reg : 4'd0;
            out_value_reg <= cmd.load_word ? rd_data_reg : 16'd0;
            out_last_reg  <= cmd.load_status || sts.ch_last;
            out_err_reg   <= cmd.frame_bad;
            out_lost_reg  <= lost_next;
            out_seen_reg  <= seen_next;
            out_good_reg  <= good_next;
            out_bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_word)
        begin
            word_mem[widx[AW-1:0]] <= {in_byte, lo_hold_reg};
        end
        rd_data_reg <= word_mem[ch_reg[AW-1:0]];
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_kind_reg;
    assign result.channel_index  = out_index_reg;
    assign result.channel_value  = out_value_reg;
    assign result.last           = out_last_reg;
    assign result.checksum_error = out_err_reg;
    assign result.link_timeout   = out_lost_reg;
    assign result.link_seen      = out_seen_reg;
    assign result.good_frames    = out_good_reg;
    assign result.bad_frames     = out_bad_reg;

endmodule

/* hdl/rc_serial_frame_receiver.sv */
// RC serial frame receiver, top level.
// Depends on rcsfr_pkg, rcsfr_in_if, rcsfr_out_if, rcsfr_ctrl, rcsfr_dpath.
//
// Usage:
//   item:   one request per received serial byte (action 0) or per
//           millisecond tick (action 1), valid/ready handshake.
//   result: status words and channel words, valid/ready handshake.
//   cfg_wr_en/cfg_wr_data: writes lost_timeout_ms; write only while idle.
// Every request but the last byte of a good frame gives one status result,
// registered on acceptance. A new request is taken in the same
// cycle the pending result is taken, so the sustained rate is one request per
// cycle while the result side keeps up.
// The last byte of a good frame starts the emit sequencer: CHANNELS channel
// words, each read from the store and then loaded as a result, the final one
// marked last; no request is taken until the last word is loaded.
// A stalled result side holds the result register and blocks new requests.
// Reset clears the hunter, counters, age and flags; lost_timeout_ms returns
// to 100. The word store needs no clearing; each frame writes it before use.
`include "rc_serial_frame_receiver_defines.svh"

module rc_serial_frame_receiver
    import rcsfr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    rcsfr_in_if.sink    item,
    rcsfr_out_if.source result
);

    rcsfr_cmd_t cmd;
    rcsfr_sts_t sts;
    logic       in_ready;

    assign item.ready = in_ready;

    rcsfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_action (item.action),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rcsfr_dpath #(
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_byte     (item.rx_byte),
        .cmd         (cmd),
        .sts         (sts),
        .result      (result)
    );

    // a request is only taken when the result register can be reloaded
    `RCSFR_ASSERT_NOW(a_ready_needs_slot, clk, rst_n, item.ready, (!result.valid || result.ready))
    // a good frame closes the request side for the emit sequence
    `RCSFR_ASSERT_NEXT(a_good_blocks_input, clk, rst_n, cmd.frame_good, !item.ready)
    // channel words never flag a checksum error
    `RCSFR_ASSERT_NOW(a_word_no_error, clk, rst_n, (result.valid && result.kind),
                      !result.checksum_error)
    // channel words come from a good frame, so link seen is already set
    `RCSFR_ASSERT_NOW(a_word_has_seen, clk, rst_n, (result.valid && result.kind), result.link_seen)

endmodule

/* sim/tb_rc_serial_frame_receiver.sv */
`timescale 1ns / 100ps
// Testbench for rc_serial_frame_receiver: directed hunter, checksum and timeout tests,
// then random frame/tick traffic, all checked against a cycle-free model of the receiver.
// Needs rcsfr_pkg, rcsfr_in_if, rcsfr_out_if and the receiver RTL.
module tb_rc_serial_frame_receiver;
    import rcsfr_pkg::*;

    localparam int   NUM_CH       = CHANNELS_DEF;
    localparam logic ACT_BYTE     = 1'b0;
    localparam logic ACT_TICK     = 1'b1;
    localparam int   PAT_RANDOM   = 0;
    localparam int   PAT_ZERO     = 1;
    localparam int   PAT_ONES     = 2;
    localparam int   SETTLE_CYCLES = 4;

    typedef enum logic [1:0] {HUNT_LEN, HUNT_CMD, HUNT_PAY} hunt_t;

    typedef struct {
        logic        kind;
        logic [3:0]  idx;
        logic [15:0] value;
        logic        last;
        logic        err;
        logic        lost;
        logic        seen;
        logic [15:0] good;
        logic [15:0] bad;
    } rx_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    rcsfr_in_if  req_if();
    rcsfr_out_if res_if();

    rc_serial_frame_receiver u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (req_if),
        .result      (res_if)
    );

    // receiver model state
    logic [15:0] timeout_set = TIMEOUT_RESET;
    hunt_t       hunter      = HUNT_LEN;
    logic [5:0]  frame_pos   = '0;
    logic [7:0]  frame_buf [0:FRAME_BYTES-1];
    logic [15:0] link_age    = '0;
    logic        link_up     = 1'b0;
    logic        link_lost   = 1'b0;
    logic [15:0] good_total  = '0;
    logic [15:0] bad_total   = '0;

    rx_word_t due_words[$];
    int       mismatches     = 0;
    int       requests_sent  = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic void push_word(logic kind, logic [3:0] idx, logic [15:0] value,
                                      logic is_last, logic err);
        rx_word_t w;
        w.kind  = kind;
        w.idx   = idx;
        w.value = value;
        w.last  = is_last;
        w.err   = err;
        w.lost  = link_lost;
        w.seen  = link_up;
        w.good  = good_total;
        w.bad   = bad_total;
        due_words.push_back(w);
    endfunction

    function automatic void compute_outcome(logic act, logic [7:0] b);
        logic [15:0] sum;
        logic [15:0] got;
        logic        err;
        err = 1'b0;
        if (act == ACT_TICK)
        begin
            if (link_age != AGE_MAX)
                link_age = link_age + 16'd1;
            if (link_up)
                link_lost = (link_age > timeout_set);
        end
        else
        begin
            case (hunter)
                HUNT_CMD:
                begin
                    // a repeated length byte keeps waiting for the command byte
                    if (b == BYTE_CMD)
                    begin
                        frame_buf[1] = b;
                        frame_pos    = 6'd2;
                        hunter       = HUNT_PAY;
                    end
                    else if (b != BYTE_LEN)
                    begin
                        hunter    = HUNT_LEN;
                        frame_pos = '0;
                    end
                end
                HUNT_PAY:
                begin
                    if (frame_pos < FRAME_BYTES)
                        frame_buf[frame_pos[4:0]] = b;
                    frame_pos = frame_pos + 6'd1;
                    if (frame_pos >= FRAME_BYTES)
                    begin
                        hunter    = HUNT_LEN;
                        frame_pos = '0;
                        sum       = '0;
                        for (int i = 0; i < FRAME_BYTES - 2; i++)
                            sum = sum + {8'd0, frame_buf[i]};
                        got = {frame_buf[FRAME_BYTES-1], frame_buf[FRAME_BYTES-2]};
                        if (16'(SUM_BASE - sum) == got)
                        begin
                            link_lost  = 1'b0;
                            link_up    = 1'b1;
                            link_age   = '0;
                            good_total = good_total + 16'd1;
                            for (int ch = 0; ch < NUM_CH; ch++)
                                push_word(KIND_CHANNEL, 4'(ch),
                                          {frame_buf[3+2*ch], frame_buf[2+2*ch]},
                                          ch == NUM_CH - 1, 1'b0);
                            return;
                        end
                        bad_total = bad_total + 16'd1;
                        err       = 1'b1;
                    end
                end
                default:
                begin
                    if (b == BYTE_LEN)
                    begin
                        frame_buf[0] = b;
                        frame_pos    = 6'd1;
                        hunter       = HUNT_CMD;
                    end
                    else
                        hunter = HUNT_LEN;
                end
            endcase
        end
        push_word(KIND_STATUS, 4'd0, 16'd0, 1'b1, err);
    endfunction

    function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // results are compared before the request of the same edge is modeled
    always @(posedge clk)
    begin : compare_words
        rx_word_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("result with no request pending");
                    mismatches++;
                end
                else
                begin
                    want = due_words.pop_front();
                    check_field("kind", 16'(want.kind), 16'(res_if.kind));
                    check_field("channel_index", 16'(want.idx), 16'(res_if.channel_index));
                    check_field("channel_value", want.value, res_if.channel_value);
                    check_field("last", 16'(want.last), 16'(res_if.last));
                    check_field("checksum_error", 16'(want.err),
                                16'(res_if.checksum_error));
                    check_field("link_timeout", 16'(want.lost), 16'(res_if.link_timeout));
                    check_field("link_seen", 16'(want.seen), 16'(res_if.link_seen));
                    check_field("good_frames", want.good, res_if.good_frames);
                    check_field("bad_frames", want.bad, res_if.bad_frames);
                end
            end
            if (req_if.valid && req_if.ready)
                compute_outcome(req_if.action, req_if.rx_byte);
        end
    end

    task automatic send_request(input logic act, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.action  <= act;
        req_if.rx_byte <= b;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // nbytes below FRAME_BYTES sends a truncated frame
    task automatic send_frame(input bit corrupt, input int pattern, input int nbytes);
        logic [7:0]  fb [0:FRAME_BYTES-1];
        logic [15:0] sum;
        fb[0] = BYTE_LEN;
        fb[1] = BYTE_CMD;
        for (int i = 2; i < FRAME_BYTES - 2; i++)
            fb[i] = (pattern == PAT_ZERO) ? 8'h00 :
                    (pattern == PAT_ONES) ? 8'hFF : 8'($urandom_range(0, 255));
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 2; i++)
            sum = sum + {8'd0, fb[i]};
        sum = SUM_BASE - sum;
        fb[FRAME_BYTES-2] = sum[7:0];
        fb[FRAME_BYTES-1] = sum[15:8];
        if (corrupt)
            fb[FRAME_BYTES - 2 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < nbytes; i++)
            send_request(ACT_BYTE, fb[i]);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        timeout_set = value;
    endtask

    task automatic test_hunter_sync();
        // ticks before any good frame must not raise signal lost
        repeat (3) send_request(ACT_TICK, 8'hFF);
        send_request(ACT_BYTE, 8'h00);
        send_request(ACT_BYTE, 8'hFF);
        send_request(ACT_BYTE, BYTE_CMD);
        send_request(ACT_BYTE, BYTE_LEN);
        send_request(ACT_BYTE, 8'h7F);
        // lone length byte, then a frame: length byte seen twice before the command
        send_request(ACT_BYTE, BYTE_LEN);
        send_frame(1'b0, PAT_ONES, FRAME_BYTES);
    endtask

    task automatic test_frame_checksum();
        send_frame(1'b1, PAT_RANDOM, FRAME_BYTES);
        send_frame(1'b0, PAT_ZERO, FRAME_BYTES);
        drain_results();
        send_frame(1'b0, PAT_RANDOM, FRAME_BYTES);
        send_frame(1'b1, PAT_ONES, FRAME_BYTES);
    endtask

    task automatic test_lost_timeout();
        write_timeout(16'd0);
        send_frame(1'b0, PAT_RANDOM, FRAME_BYTES);
        repeat (2) send_request(ACT_TICK, 8'h00);
        write_timeout(16'd1);
        send_frame(1'b0, PAT_RANDOM, FRAME_BYTES);
        repeat (3) send_request(ACT_TICK, 8'h00);
        write_timeout(16'hFFFF);
        send_frame(1'b0, PAT_RANDOM, FRAME_BYTES);
        repeat (2) send_request(ACT_TICK, 8'h00);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_req);
        int start_cnt;
        int pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_timeout(16'($urandom_range(1, 12)));
        start_cnt = requests_sent;
        while (requests_sent - start_cnt < n_req)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_frame($urandom_range(0, 4) == 0, PAT_RANDOM, FRAME_BYTES);
            else if (pick < 48)
                send_frame(1'b0, $urandom_range(PAT_ZERO, PAT_ONES), FRAME_BYTES);
            else if (pick < 70)
                repeat ($urandom_range(1, 8)) send_request(ACT_TICK, 8'($urandom));
            else if (pick < 85)
            begin
                // noise, biased toward the sync bytes
                repeat ($urandom_range(1, 4))
                    send_request(ACT_BYTE, ($urandom_range(0, 2) == 0) ?
                                 (($urandom_range(0, 1) == 0) ? BYTE_LEN : BYTE_CMD) :
                                 8'($urandom));
            end
            else if (pick < 95)
                send_frame(1'b0, PAT_RANDOM, $urandom_range(1, FRAME_BYTES - 1));
            else
                write_timeout(16'($urandom_range(1, 20)));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_if.valid   = 1'b0;
        req_if.action  = ACT_BYTE;
        req_if.rx_byte = '0;
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_buf[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 15;
        recv_stall_pct = 67;
        test_hunter_sync();
        test_frame_checksum();
        test_lost_timeout();
        test_random_traffic(15, 67, 80);
        test_random_traffic(67, 15, 80);
        test_random_traffic(0, 0, 80);
        drain_results();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
